[rtl/midi_cc_to_sysex_mapper_core_macros.svh]
// Assertion macros for the MIDI CC to SysEx mapper.
// Included by the top level; no other dependencies.
`ifndef MIDI_CC_TO_SYSEX_MAPPER_CORE_MACROS_SVH
`define MIDI_CC_TO_SYSEX_MAPPER_CORE_MACROS_SVH

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define MCSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcsm: same-cycle check failed");

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define MCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcsm: next-cycle check failed");

`endif

[rtl/mcsm_pkg.sv]
// Shared types, constants, microcode ROM and page math for the CC mapper.
// No dependencies.
package mcsm_pkg;

    localparam int CONTROLLERS_DEFAULT = 128;
    localparam int PAGES_DEFAULT       = 8;

    localparam logic [7:0] CC_STATUS_HI  = 8'hB0;
    localparam logic [7:0] ENTRY_PAGE    = 8'hFF;
    localparam logic [7:0] ENTRY_SAVE    = 8'hFE;
    localparam logic [7:0] CTL_MASK      = 8'h7F;
    localparam logic [3:0] PCOUNT_RESET  = 4'd4;

    // APB register indexes
    localparam logic REG_CHANNEL = 1'b0;
    localparam logic REG_PCOUNT  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CTL,
        PH_VALUE
    } phase_t;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_CHANNEL,
        SRC_STATUS,
        SRC_CTL,
        SRC_DATA,
        SRC_ENTRY
    } src_t;

    typedef struct packed {
        src_t       src;
        logic [7:0] konst;
        logic       last;
    } ucode_word_t;

    // Program entry points and the last microcode address
    localparam logic [3:0] UPC_PASS  = 4'd0;
    localparam logic [3:0] UPC_CC    = 4'd1;
    localparam logic [3:0] UPC_SYSEX = 4'd4;
    localparam logic [3:0] UPC_LAST  = 4'd13;

    function automatic ucode_word_t ucode(input logic [3:0] upc);
        ucode_word_t w;
        w = '{src: SRC_CONST, konst: 8'h00, last: 1'b1};
        unique case (upc)
            4'd0:  w = '{src: SRC_DATA,    konst: 8'h00, last: 1'b1};
            4'd1:  w = '{src: SRC_STATUS,  konst: 8'h00, last: 1'b0};
            4'd2:  w = '{src: SRC_CTL,     konst: 8'h00, last: 1'b0};
            4'd3:  w = '{src: SRC_DATA,    konst: 8'h00, last: 1'b1};
            4'd4:  w = '{src: SRC_CONST,   konst: 8'hF0, last: 1'b0};
            4'd5:  w = '{src: SRC_CONST,   konst: 8'h41, last: 1'b0};
            4'd6:  w = '{src: SRC_CONST,   konst: 8'h36, last: 1'b0};
            4'd7:  w = '{src: SRC_CHANNEL, konst: 8'h00, last: 1'b0};
            4'd8:  w = '{src: SRC_CONST,   konst: 8'h24, last: 1'b0};
            4'd9:  w = '{src: SRC_CONST,   konst: 8'h20, last: 1'b0};
            4'd10: w = '{src: SRC_CONST,   konst: 8'h01, last: 1'b0};
            4'd11: w = '{src: SRC_ENTRY,   konst: 8'h00, last: 1'b0};
            4'd12: w = '{src: SRC_DATA,    konst: 8'h00, last: 1'b0};
            4'd13: w = '{src: SRC_CONST,   konst: 8'hF7, last: 1'b1};
            default: w = '{src: SRC_CONST, konst: 8'h00, last: 1'b1};
        endcase
        return w;
    endfunction

    // 127 / pc for pc clamped to 1..8
    function automatic logic [6:0] page_div(input logic [3:0] pc);
        logic [6:0] d;
        unique case (pc)
            4'd0, 4'd1: d = 7'd127;
            4'd2:       d = 7'd63;
            4'd3:       d = 7'd42;
            4'd4:       d = 7'd31;
            4'd5:       d = 7'd25;
            4'd6:       d = 7'd21;
            4'd7:       d = 7'd18;
            default:    d = 7'd15;
        endcase
        return d;
    endfunction

    // value / div saturated at pages-1, as a bank of threshold compares
    function automatic logic [2:0] page_sel(input logic [3:0] pc, input logic [7:0] value,
                                            input int pages);
        logic [6:0]  d;
        logic [10:0] thr;
        logic [2:0]  np;
        d  = page_div(pc);
        np = 3'd0;
        for (int k = 1; k < 8; k++) begin
            thr = 11'(k) * {4'b0, d};
            if (k < pages && {3'b0, value} >= thr)
                np = 3'(k);
        end
        return np;
    endfunction

endpackage

[rtl/mcsm_channels.sv]
// Handshake channel interfaces for the CC mapper: input items and output bytes.
// Depends on nothing.
interface mcsm_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] midi_byte;
    logic [6:0] map_controller;
    logic [2:0] map_page;
    logic [7:0] map_entry;

    modport source (output valid, command, midi_byte, map_controller, map_page, map_entry,
                    input ready);
    modport sink   (input valid, command, midi_byte, map_controller, map_page, map_entry,
                    output ready);
endinterface

interface mcsm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

[rtl/midi_cc_to_sysex_mapper_core.sv]
// Flow: a passed-through byte goes through the RUN state to the output register; a translated CC
// (third byte) goes through the LOOKUP and RUN states, then 1 byte per cycle while the output is ready.
// Throughput: one output byte per cycle from the microcode step counter while the output is
// ready; a SysEx run is 10 bytes, a re-sent CC 3; capture and table-write items start no run.
// Reset: a clearing pass zeroes the CONTROLLERS*PAGES mapping table (1024 entries at
// defaults), one entry per cycle, during which no input transfer is taken.
module midi_cc_to_sysex_mapper_core #(
    parameter int CONTROLLERS = mcsm_pkg::CONTROLLERS_DEFAULT,
    parameter int PAGES       = mcsm_pkg::PAGES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    mcsm_in_if.sink     items,
    mcsm_out_if.source  results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
`include "midi_cc_to_sysex_mapper_core_macros.svh"

    localparam int DEPTH = CONTROLLERS * PAGES;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [3:0] channel_reg;
    logic [3:0] pcount_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= '0;
            pcount_reg  <= mcsm_pkg::PCOUNT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == mcsm_pkg::REG_PCOUNT)
                pcount_reg <= pwdata[3:0];
            else
                channel_reg <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[2] == mcsm_pkg::REG_PCOUNT) ? {28'b0, pcount_reg}
                                                       : {28'b0, channel_reg};

    // control state
    mcsm_pkg::state_t state_reg, state_next;
    mcsm_pkg::phase_t phase_reg, phase_next;
    logic [6:0]       held_ctl_reg, held_ctl_next;
    logic [2:0]       page_reg, page_next;
    logic [AW-1:0]    clear_addr_reg, clear_addr_next;
    logic [3:0]       upc_reg, upc_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [7:0] data_reg, data_next;
    logic [7:0] entry_reg, entry_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    // mapping table
    logic [7:0]    table_mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_page_ok;

    assign rd_addr    = AW'(held_ctl_reg) * AW'(PAGES) + AW'(page_reg);
    assign wr_addr    = AW'(items.map_controller) * AW'(PAGES) + AW'(items.map_page);
    assign wr_page_ok = {1'b0, items.map_page} < 4'(PAGES);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= table_mem[rd_addr];
    end

    // microcode datapath
    mcsm_pkg::ucode_word_t uword;
    logic [7:0]            status_byte;
    logic [7:0]            sel_byte;
    logic                  run_load;

    assign uword       = mcsm_pkg::ucode(upc_reg);
    assign status_byte = mcsm_pkg::CC_STATUS_HI | {4'b0, channel_reg};

    always_comb
    begin
        unique case (uword.src)
            mcsm_pkg::SRC_CONST:   sel_byte = uword.konst;
            mcsm_pkg::SRC_CHANNEL: sel_byte = {4'b0, channel_reg};
            mcsm_pkg::SRC_STATUS:  sel_byte = status_byte;
            mcsm_pkg::SRC_CTL:     sel_byte = {1'b0, held_ctl_reg};
            mcsm_pkg::SRC_DATA:    sel_byte = data_reg;
            mcsm_pkg::SRC_ENTRY:   sel_byte = entry_reg;
            default:               sel_byte = uword.konst;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mcsm_pkg::ST_CLEAR;
            phase_reg      <= mcsm_pkg::PH_IDLE;
            held_ctl_reg   <= '0;
            page_reg       <= '0;
            clear_addr_reg <= '0;
            upc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            held_ctl_reg   <= held_ctl_next;
            page_reg       <= page_next;
            clear_addr_reg <= clear_addr_next;
            upc_reg        <= upc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        entry_reg    <= entry_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        held_ctl_next   = held_ctl_reg;
        page_next       = page_reg;
        clear_addr_next = clear_addr_reg;
        upc_next        = upc_reg;
        data_next       = data_reg;
        entry_next      = entry_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_addr;
        mem_wdata       = items.map_entry;
        run_load        = 1'b0;

        unique case (state_reg)
            mcsm_pkg::ST_CLEAR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = clear_addr_reg;
                mem_wdata       = '0;
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == AW'(DEPTH - 1))
                    state_next = mcsm_pkg::ST_IDLE;
            end
            mcsm_pkg::ST_IDLE:
            begin
                if (items.valid)
                begin
                    if (items.command)
                        mem_we = wr_page_ok;
                    else
                    begin
                        unique case (phase_reg)
                            mcsm_pkg::PH_IDLE:
                            begin
                                if (items.midi_byte == status_byte)
                                    phase_next = mcsm_pkg::PH_CTL;
                                else
                                begin
                                    data_next  = items.midi_byte;
                                    upc_next   = mcsm_pkg::UPC_PASS;
                                    state_next = mcsm_pkg::ST_RUN;
                                end
                            end
                            mcsm_pkg::PH_CTL:
                            begin
                                held_ctl_next = items.midi_byte[6:0];
                                phase_next    = mcsm_pkg::PH_VALUE;
                            end
                            mcsm_pkg::PH_VALUE:
                            begin
                                // table read is issued at this edge
                                data_next  = items.midi_byte;
                                phase_next = mcsm_pkg::PH_IDLE;
                                state_next = mcsm_pkg::ST_LOOKUP;
                            end
                            default:
                                phase_next = mcsm_pkg::PH_IDLE;
                        endcase
                    end
                end
            end
            mcsm_pkg::ST_LOOKUP:
            begin
                priority if (rdata_reg == mcsm_pkg::ENTRY_PAGE)
                begin
                    page_next  = mcsm_pkg::page_sel(pcount_reg, data_reg, PAGES);
                    state_next = mcsm_pkg::ST_IDLE;
                end
                else if (rdata_reg == mcsm_pkg::ENTRY_SAVE)
                    state_next = mcsm_pkg::ST_IDLE;
                else if (rdata_reg != 8'h00)
                begin
                    entry_next = rdata_reg;
                    upc_next   = mcsm_pkg::UPC_SYSEX;
                    state_next = mcsm_pkg::ST_RUN;
                end
                else
                begin
                    upc_next   = mcsm_pkg::UPC_CC;
                    state_next = mcsm_pkg::ST_RUN;
                end
            end
            mcsm_pkg::ST_RUN:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    run_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = sel_byte;
                    out_last_next  = uword.last;
                    if (uword.last)
                        state_next = mcsm_pkg::ST_IDLE;
                    else
                        upc_next = upc_reg + 1'b1;
                end
            end
        endcase
    end

    assign items.ready         = (state_reg == mcsm_pkg::ST_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.out_byte    = out_byte_reg;
    assign results.last_of_run = out_last_reg;

    `MCSM_ASSERT_NOW(a_upc_range, clk, rst_n, state_reg == mcsm_pkg::ST_RUN,
                     upc_reg <= mcsm_pkg::UPC_LAST)
    `MCSM_ASSERT_NOW(a_page_range, clk, rst_n, 1'b1, {1'b0, page_reg} < 4'(PAGES))
    `MCSM_ASSERT_NEXT(a_last_ends_run, clk, rst_n, run_load && uword.last,
                      state_reg == mcsm_pkg::ST_IDLE && results.valid && results.last_of_run)

endmodule

[dv/tb.sv]
// Self-checking testbench for midi_cc_to_sysex_mapper_core: directed and random MIDI traffic.
// Uses mcsm_pkg and the mcsm_in_if / mcsm_out_if channel interfaces from the RTL.
// Expected output bytes come from an in-bench model of the mapper and are compared in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_MIDI  = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] MFR_ID      = 8'h41;
    localparam logic [7:0] MODEL_ID    = 8'h36;
    localparam logic [7:0] SX_OPCODE   = 8'h24;
    localparam logic [7:0] SX_GROUP    = 8'h20;
    localparam logic [7:0] SX_SUBGROUP = 8'h01;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    localparam int IDLE_PCT     = 14;
    localparam int DRAIN_CYCLES = 12;
    // covers the table clearing pass after reset with plenty of margin
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic       command;
        logic [7:0] midi_byte;
        logic [6:0] map_controller;
        logic [2:0] map_page;
        logic [7:0] map_entry;
    } map_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } midi_out_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mcsm_in_if  items_ch();
    mcsm_out_if results_ch();

    midi_cc_to_sysex_mapper_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mapper model state
    logic [3:0]        chan_reg;
    logic [3:0]        pcount_reg;
    mcsm_pkg::phase_t  cap_phase;
    logic [6:0]        held_ctl;
    logic [2:0]        cur_page;
    logic [7:0]        map_table [0:1023];

    midi_out_t pending_bytes[$];
    int        errors = 0;
    int        quiet_cycles = 0;
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] cc_status();
        return mcsm_pkg::CC_STATUS_HI + {4'b0, chan_reg};
    endfunction

    // Advance the model by one accepted item and queue the bytes it produces.
    function automatic void translate_item(map_item_t it);
        logic [7:0] entry;
        logic [7:0] run [10];
        int         run_len;
        int         pc;
        int         new_page;
        run_len = 0;
        if (it.command == CMD_TABLE)
        begin
            map_table[{it.map_controller, it.map_page}] = it.map_entry;
            return;
        end
        case (cap_phase)
            mcsm_pkg::PH_IDLE:
            begin
                if (it.midi_byte == cc_status())
                    cap_phase = mcsm_pkg::PH_CTL;
                else
                begin
                    run[0]  = it.midi_byte;
                    run_len = 1;
                end
            end
            mcsm_pkg::PH_CTL:
            begin
                // status bytes here are data, not a restart
                held_ctl  = 7'(it.midi_byte & mcsm_pkg::CTL_MASK);
                cap_phase = mcsm_pkg::PH_VALUE;
            end
            mcsm_pkg::PH_VALUE:
            begin
                entry     = map_table[{held_ctl, cur_page}];
                cap_phase = mcsm_pkg::PH_IDLE;
                if (entry == mcsm_pkg::ENTRY_PAGE)
                begin
                    pc = int'(pcount_reg);
                    if (pc < 1)
                        pc = 1;
                    if (pc > 8)
                        pc = 8;
                    new_page = int'(it.midi_byte) / (127 / pc);
                    if (new_page > mcsm_pkg::PAGES_DEFAULT - 1)
                        new_page = mcsm_pkg::PAGES_DEFAULT - 1;
                    cur_page = 3'(new_page);
                end
                else if (entry == mcsm_pkg::ENTRY_SAVE)
                begin
                    // save entry: swallowed
                end
                else if (entry != 8'h00)
                begin
                    run = '{SYSEX_START, MFR_ID, MODEL_ID, {4'b0, chan_reg}, SX_OPCODE,
                            SX_GROUP, SX_SUBGROUP, entry, it.midi_byte, SYSEX_END};
                    run_len = 10;
                end
                else
                begin
                    run[0]  = cc_status();
                    run[1]  = {1'b0, held_ctl};
                    run[2]  = it.midi_byte;
                    run_len = 3;
                end
            end
            default: cap_phase = mcsm_pkg::PH_IDLE;
        endcase
        for (int i = 0; i < run_len; i++)
            pending_bytes.push_back('{run[i], i == run_len - 1});
    endfunction

    task automatic send_item(map_item_t it);
        while (!tx_steady && $urandom_range(99) < IDLE_PCT)
        begin
            items_ch.valid <= 1'b0;
            @(posedge clk);
        end
        items_ch.valid          <= 1'b1;
        items_ch.command        <= it.command;
        items_ch.midi_byte      <= it.midi_byte;
        items_ch.map_controller <= it.map_controller;
        items_ch.map_page       <= it.map_page;
        items_ch.map_entry      <= it.map_entry;
        do
            @(posedge clk);
        while (!items_ch.ready);
        translate_item(it);
    endtask

    // unused fields carry random values so their bits still toggle
    task automatic send_midi(logic [7:0] b);
        send_item('{CMD_MIDI, b, 7'($urandom), 3'($urandom), 8'($urandom)});
    endtask

    task automatic send_cc(logic [7:0] ctl_byte, logic [7:0] value);
        send_midi(cc_status());
        send_midi(ctl_byte);
        send_midi(value);
    endtask

    task automatic write_entry(logic [6:0] ctl, logic [2:0] pg, logic [7:0] entry);
        send_item('{CMD_TABLE, 8'($urandom), ctl, pg, entry});
    endtask

    task automatic write_reg(logic idx, logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == mcsm_pkg::REG_CHANNEL)
            chan_reg = value;
        else
            pcount_reg = value;
    endtask

    // Close any open capture, hold off input until every expected byte is out, then let
    // the block settle so a register write lands while it is idle.
    task automatic drain_and_close();
        while (cap_phase != mcsm_pkg::PH_IDLE)
            send_midi(8'h00);
        items_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_passthrough();
        send_midi(8'h00);
        send_midi(8'hFF);
        send_midi(mcsm_pkg::CC_STATUS_HI + 8'h01);
        // empty table after reset: the control change comes back unchanged
        send_cc(8'h7F, 8'h7F);
    endtask

    task automatic test_entry_kinds();
        write_entry(7'h7F, 3'd0, 8'h80);
        write_entry(7'h30, 3'd0, 8'hFD);
        write_entry(7'h05, 3'd0, mcsm_pkg::ENTRY_PAGE);
        write_entry(7'h05, 3'd7, mcsm_pkg::ENTRY_PAGE);
        write_entry(7'h06, 3'd7, mcsm_pkg::ENTRY_SAVE);
        send_cc(8'h7F, 8'h00);
        // status byte as controller: masked to 0x30
        send_cc(mcsm_pkg::CC_STATUS_HI, 8'h10);
        // controller bit 7 masked off; full-scale value saturates the page at 7
        send_cc(8'h85, 8'hFF);
        send_cc(8'h06, 8'h40);
        send_cc(8'h7F, 8'h7F);
        send_cc(8'h05, 8'h00);
    endtask

    task automatic test_random_traffic(logic [3:0] chan, logic [3:0] pc, int n_items,
                                       bit steady);
        int         sent;
        int         r;
        logic [6:0] hot [4];
        logic [6:0] ctl;
        logic [2:0] pg;
        logic [7:0] entry;
        drain_and_close();
        write_reg(mcsm_pkg::REG_CHANNEL, chan);
        write_reg(mcsm_pkg::REG_PCOUNT, pc);
        tx_steady = steady;
        rx_steady = steady;
        foreach (hot[i])
            hot[i] = 7'($urandom);
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                ctl = $urandom_range(1) ? hot[$urandom_range(3)] : 7'($urandom);
                // mostly the live page so the write is seen by a later lookup
                pg  = ($urandom_range(99) < 60) ? cur_page : 3'($urandom);
                r   = $urandom_range(99);
                if (r < 25)
                    entry = mcsm_pkg::ENTRY_PAGE;
                else if (r < 35)
                    entry = mcsm_pkg::ENTRY_SAVE;
                else if (r < 50)
                    entry = 8'h00;
                else
                    entry = 8'($urandom);
                write_entry(ctl, pg, entry);
                sent += 1;
            end
            else if (r < 72)
            begin
                ctl = ($urandom_range(99) < 70) ? hot[$urandom_range(3)] : 7'($urandom);
                send_cc({1'($urandom), ctl}, 8'($urandom));
                sent += 3;
            end
            else if (r < 82)
            begin
                // truncated control change; following traffic completes the capture
                send_midi(cc_status());
                sent += 1;
                if ($urandom_range(1))
                begin
                    send_midi(8'($urandom));
                    sent += 1;
                end
            end
            else
            begin
                send_midi(8'($urandom));
                sent += 1;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        midi_out_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                errors++;
                $error("unexpected transfer: out_byte %02h last_of_run %0b",
                       results_ch.out_byte, results_ch.last_of_run);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (results_ch.out_byte !== want.out_byte)
                begin
                    errors++;
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           want.out_byte, results_ch.out_byte);
                end
                if (results_ch.last_of_run !== want.last_of_run)
                begin
                    errors++;
                    $error("last_of_run mismatch: expected %0b, actual %0b",
                           want.last_of_run, results_ch.last_of_run);
                end
            end
        end
        results_ch.ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (items_ch.valid && items_ch.ready)
            || (results_ch.valid && results_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        chan_reg   = 4'd0;
        pcount_reg = mcsm_pkg::PCOUNT_RESET;
        cap_phase  = mcsm_pkg::PH_IDLE;
        held_ctl   = '0;
        cur_page   = '0;
        foreach (map_table[i])
            map_table[i] = 8'h00;

        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        items_ch.valid          <= 1'b0;
        items_ch.command        <= CMD_MIDI;
        items_ch.midi_byte      <= '0;
        items_ch.map_controller <= '0;
        items_ch.map_page       <= '0;
        items_ch.map_entry      <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_passthrough();
        test_entry_kinds();
        test_random_traffic(4'd15, 4'd0, 90, 1'b0);
        test_random_traffic(4'd0, 4'd15, 90, 1'b0);
        test_random_traffic(4'($urandom), 4'd1, 90, 1'b1);
        test_random_traffic(4'($urandom), 4'd8, 90, 1'b0);
        test_random_traffic(4'($urandom), 4'($urandom), 90, 1'b0);

        drain_and_close();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/mcsm_pkg.sv
rtl/mcsm_channels.sv
rtl/midi_cc_to_sysex_mapper_core.sv
dv/tb.sv
